>>> design/adeq_pkg.sv
`timescale 1ns / 1ps

package adeq_pkg;

   localparam int DataWidth    = 32;
   localparam int DefaultDepth = 8;
   localparam int CmdWidth     = 3;
   localparam int StatusWidth  = 2;

   // Command codes carried on the input tuser.
   localparam logic [CmdWidth-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_POP_REAR   = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_MOD_FRONT  = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_MOD_REAR   = 3'd5;
   localparam logic [CmdWidth-1:0] CMD_TRAVERSE   = 3'd6;

   // Status codes carried on the result tuser.
   localparam logic [StatusWidth-1:0] ST_OK     = 2'd0;
   localparam logic [StatusWidth-1:0] ST_FULL   = 2'd1;
   localparam logic [StatusWidth-1:0] ST_NOROOM = 2'd2;
   localparam logic [StatusWidth-1:0] ST_EMPTY  = 2'd3;

endpackage

>>> design/adeq_ram.sv
`timescale 1ns / 1ps

module adeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/array_deque_engine_core.sv
`timescale 1ns / 1ps
// A push, and any command on an empty deque, gives its item in the cycle after accept; pop,
// modify and traverse give their first item via a RAM read and then the result register.
// Commands are taken one at a time; each traverse entry is a RAM read followed by a load of
// the single result register; a stalled result holds back the next read. The next command is
// taken the cycle after the last item of the one before it is taken.
// Reset (synchronous, active high) empties the deque; the store contents are not cleared.

module array_deque_engine_core #(
   parameter int DEPTH = adeq_pkg::DefaultDepth
) (
   input  logic                             clock,
   input  logic                             reset,
   // Command items.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [adeq_pkg::DataWidth-1:0]   req_tdata,   // [31:0] data_in
   input  logic [adeq_pkg::CmdWidth-1:0]    req_tuser,   // [2:0] cmd
   // Result items.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [adeq_pkg::DataWidth-1:0]   rsp_tdata,   // [31:0] data_out
   output logic [adeq_pkg::StatusWidth-1:0] rsp_tuser,   // [1:0] status
   output logic                             rsp_tlast    // last item of this command
);

   import adeq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a command
   localparam logic [1:0] S_READ = 2'd1;   // RAM read data is valid this cycle
   localparam logic [1:0] S_NEXT = 2'd2;   // traverse: wait for a free result slot

   logic [1:0]             state_ff, state_in;
   logic [AW-1:0]          front_ff, front_in;
   logic [AW-1:0]          rear_ff, rear_in;
   logic                   empty_ff, empty_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [CmdWidth-1:0]    kind_ff, kind_in;
   logic signed [DataWidth-1:0] wdata_ff, wdata_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [DataWidth-1:0]   rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [DataWidth-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [DataWidth-1:0]   ram_rd_data;

   logic                   req_fire;
   logic                   rsp_load;
   logic                   is_full;
   logic                   read_last;
   logic signed [DataWidth-1:0] data_in;

   adeq_ram #(
      .WIDTH (DataWidth),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign data_in    = req_tdata;
   // A new command is taken only when the sequencer is idle and the result slot is free,
   // so a command never overlaps the read-modify-write of the one before it.
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign is_full    = (front_ff == '0) && (rear_ff == LastIdx);
   // The entry being read is the last item of its command, except a traverse entry before the rear.
   assign read_last  = (kind_ff != CMD_TRAVERSE) || (idx_ff == rear_ff);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      empty_in      = empty_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      wdata_in      = wdata_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = wdata_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               wdata_in = data_in;
               case (req_tuser)
                  CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                     rsp_load      = 1'b1;
                     rsp_data_in   = '0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = ST_OK;
                     ram_wr_data   = data_in;
                     if (empty_ff) begin
                        // First entry always lands at index zero.
                        front_in    = '0;
                        rear_in     = '0;
                        empty_in    = 1'b0;
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                     end else if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else if (req_tuser == CMD_PUSH_FRONT) begin
                        if (front_ff == '0) begin
                           rsp_status_in = ST_NOROOM;
                        end else begin
                           front_in    = front_ff - 1'b1;
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = front_ff - 1'b1;
                        end
                     end else begin
                        if (rear_ff == LastIdx) begin
                           rsp_status_in = ST_NOROOM;
                        end else begin
                           rear_in     = rear_ff + 1'b1;
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = rear_ff + 1'b1;
                        end
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_REAR, CMD_MOD_FRONT, CMD_MOD_REAR,
                  CMD_TRAVERSE: begin
                     if (empty_ff) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        if (req_tuser inside {CMD_POP_FRONT, CMD_MOD_FRONT, CMD_TRAVERSE}) begin
                           idx_in = front_ff;
                        end else begin
                           idx_in = rear_ff;
                        end
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_in;
                        state_in    = S_READ;
                        // Pops settle the positions now; the old word follows from the RAM.
                        if (req_tuser inside {CMD_POP_FRONT, CMD_POP_REAR}) begin
                           if (front_ff == rear_ff) begin
                              empty_in = 1'b1;
                              front_in = '0;
                              rear_in  = '0;
                           end else if (req_tuser == CMD_POP_FRONT) begin
                              front_in = front_ff + 1'b1;
                           end else begin
                              rear_in = rear_ff - 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                     // Unknown command: taken and dropped without a result.
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_load      = 1'b1;
            rsp_status_in = ST_OK;
            rsp_data_in   = ram_rd_data;
            rsp_last_in   = read_last;
            // Modify writes the new word back after the old one has been read out.
            if (kind_ff inside {CMD_MOD_FRONT, CMD_MOD_REAR}) begin
               ram_wr_en = 1'b1;
            end
            state_in = read_last ? S_IDLE : S_NEXT;
         end
         S_NEXT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               idx_in      = idx_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + 1'b1;
               state_in    = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         rear_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      wdata_ff      <= wdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> dv/array_deque_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deque engine, keeps its own copy of the deque
// and compares every result item against the oldest predicted one.
module array_deque_checker #(
   parameter int DEPTH = adeq_pkg::DefaultDepth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [adeq_pkg::DataWidth-1:0]   req_tdata,
   input  logic [adeq_pkg::CmdWidth-1:0]    req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [adeq_pkg::DataWidth-1:0]   rsp_tdata,
   input  logic [adeq_pkg::StatusWidth-1:0] rsp_tuser,
   input  logic                             rsp_tlast,
   output int                               fail_count,
   output int                               pending_items
);

   import adeq_pkg::*;

   localparam int IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [DataWidth-1:0]   data;
      logic                   last;
   } deque_item_type;

   logic [DataWidth-1:0] shadow_mem [DEPTH];
   logic [IdxWidth-1:0]  head_idx;
   logic [IdxWidth-1:0]  tail_idx;
   logic                 deque_empty;
   deque_item_type       expected_items [$];
   int                   errors = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns: deque mismatch: %s", $time, msg);
   endtask

   task automatic queue_item(input logic [StatusWidth-1:0] st, input logic [DataWidth-1:0] d,
                             input logic l);
      expected_items.push_back('{status: st, data: d, last: l});
   endtask

   // Applies one command to the shadow deque and queues the items it yields.
   task automatic predict_command(input logic [CmdWidth-1:0] cmd,
                                  input logic [DataWidth-1:0] value);
      logic [DataWidth-1:0] old_word;
      logic [IdxWidth-1:0]  sel;
      int                   pos;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (deque_empty) begin
               head_idx = '0;
               tail_idx = '0;
               shadow_mem[0] = value;
               deque_empty = 1'b0;
               queue_item(ST_OK, '0, 1'b1);
            end else if (head_idx == 0 && tail_idx == DEPTH - 1) begin
               queue_item(ST_FULL, '0, 1'b1);
            end else if (cmd == CMD_PUSH_FRONT) begin
               if (head_idx == 0) begin
                  queue_item(ST_NOROOM, '0, 1'b1);
               end else begin
                  head_idx = head_idx - 1'b1;
                  shadow_mem[head_idx] = value;
                  queue_item(ST_OK, '0, 1'b1);
               end
            end else if (tail_idx == DEPTH - 1) begin
               queue_item(ST_NOROOM, '0, 1'b1);
            end else begin
               tail_idx = tail_idx + 1'b1;
               shadow_mem[tail_idx] = value;
               queue_item(ST_OK, '0, 1'b1);
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (deque_empty) begin
               queue_item(ST_EMPTY, '0, 1'b1);
            end else begin
               old_word = shadow_mem[(cmd == CMD_POP_FRONT) ? head_idx : tail_idx];
               if (head_idx == tail_idx) begin
                  deque_empty = 1'b1;
                  head_idx = '0;
                  tail_idx = '0;
               end else if (cmd == CMD_POP_FRONT) begin
                  head_idx = head_idx + 1'b1;
               end else begin
                  tail_idx = tail_idx - 1'b1;
               end
               queue_item(ST_OK, old_word, 1'b1);
            end
         end
         CMD_MOD_FRONT, CMD_MOD_REAR: begin
            if (deque_empty) begin
               queue_item(ST_EMPTY, '0, 1'b1);
            end else begin
               sel = (cmd == CMD_MOD_FRONT) ? head_idx : tail_idx;
               old_word = shadow_mem[sel];
               shadow_mem[sel] = value;
               queue_item(ST_OK, old_word, 1'b1);
            end
         end
         CMD_TRAVERSE: begin
            if (deque_empty) begin
               queue_item(ST_EMPTY, '0, 1'b1);
            end else begin
               for (pos = head_idx; pos <= tail_idx; pos++) begin
                  queue_item(ST_OK, shadow_mem[pos], pos == tail_idx);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      deque_item_type got;
      deque_item_type want;
      if (reset) begin
         expected_items.delete();
         head_idx = '0;
         tail_idx = '0;
         deque_empty = 1'b1;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_command(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: rsp_tuser, data: rsp_tdata, last: rsp_tlast};
            if (expected_items.size() == 0) begin
               report_mismatch($sformatf("unexpected item status %0d data %h last %0b",
                                         got.status, got.data, got.last));
            end else begin
               want = expected_items.pop_front();
               if (got.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
               end
               if (got.data !== want.data) begin
                  report_mismatch($sformatf("data %h, expected %h", got.data, want.data));
               end
               if (got.last !== want.last) begin
                  report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
               end
            end
         end
      end
      fail_count    <= errors;
      pending_items <= expected_items.size();
   end

endmodule

>>> dv/tb_array_deque_engine_core.sv
`timescale 1ns / 1ps

module tb_array_deque_engine_core;
   import adeq_pkg::*;

   localparam int DEPTH       = DefaultDepth;
   // Number of random commands that the block acts on (unknown codes are extra).
   localparam int RandomItems = 240;
   // Length of the one long stall of the result side, in cycles.
   localparam int LongHold    = 80;
   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is the long stall plus the block's own latency.
   localparam int IdleLimit   = 2000;
   // Cycles left after the last expected item so that stray items show up.
   localparam int DrainCycles = 20;

   // The one command code that the block ignores.
   localparam logic [CmdWidth-1:0] CmdUnused = 3'd7;

   // Every input of the block starts at a known value.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [DataWidth-1:0]   req_tdata  = '0;   // [31:0] data_in
   logic [CmdWidth-1:0]    req_tuser  = CMD_PUSH_FRONT;   // [2:0] cmd
   logic                   rsp_tready = 1'b0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [DataWidth-1:0]   rsp_tdata;   // [31:0] data_out
   logic [StatusWidth-1:0] rsp_tuser;   // [1:0] status
   logic                   rsp_tlast;

   int fail_count;
   int pending_items;
   int idle_cycles   = 0;
   // Raised by the command side to ask the result side for its long stall.
   bit hold_request  = 1'b0;

   array_deque_engine_core #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The checker predicts from accepted commands and compares result items.
   array_deque_checker #(.DEPTH(DEPTH)) deque_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_items (pending_items)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: any handshake on either channel restarts the count. A run that
   // stays quiet for too long is hung and ends here as a failure.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("array_deque_engine_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one command item and returns at the edge where it is accepted.
   // Valid stays high on return, so back-to-back items keep it asserted.
   task automatic send_item(input logic [CmdWidth-1:0] cmd, input logic [DataWidth-1:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Idles the command side until every predicted item has come back. The
   // checker publishes its count through a register, hence the edge taken first.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_items != 0);
   endtask

   // In a fill phase pushes dominate so the deque reaches full and both
   // refusals; in a drain phase pops dominate so it keeps running empty.
   function automatic logic [CmdWidth-1:0] pick_command(input bit fill_phase);
      int roll;
      int push_pct;
      int pop_pct;
      roll     = $urandom_range(0, 99);
      push_pct = fill_phase ? 55 : 25;
      pop_pct  = fill_phase ? 15 : 40;
      if (roll < push_pct) begin
         return ($urandom_range(0, 2) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      end else if (roll < push_pct + pop_pct) begin
         return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
      end else if (roll < 80) begin
         return $urandom_range(0, 1) ? CMD_MOD_FRONT : CMD_MOD_REAR;
      end else if (roll < 95) begin
         return CMD_TRAVERSE;
      end
      return CmdUnused;
   endfunction

   // Mostly random words, with the signed extremes and zero mixed in.
   function automatic logic [DataWidth-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // Result side: ready follows a pattern of its own, switching between
   // always ready, mostly ready and mostly stalled. Once, on request, it holds
   // off for a long stretch while the command side keeps offering items, so
   // the block backs up and stalls its input.
   initial begin : receiver
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(8, 40);
         repeat (span) begin
            @(posedge clock);
            if (hold_request) begin
               rsp_tready <= 1'b0;
               repeat (LongHold) @(posedge clock);
               hold_request = 1'b0;
            end else begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= ($urandom_range(0, 3) != 0);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      int                  sent;
      int                  burst_left;
      int                  gap;
      bit                  hold_issued;
      bit                  pause_done;
      logic [CmdWidth-1:0] cmd;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Every pop, modify and traverse command on the empty deque first.
      send_item(CMD_POP_FRONT,  32'h0000_0000);
      send_item(CMD_POP_REAR,   32'h0000_0000);
      send_item(CMD_MOD_FRONT,  32'h1111_1111);
      send_item(CMD_MOD_REAR,   32'h2222_2222);
      send_item(CMD_TRAVERSE,   32'h0000_0000);
      // A push front into the empty deque lands in the first slot, so a
      // second push front finds no room at the front while the rear has some.
      send_item(CMD_PUSH_FRONT, 32'h7fff_ffff);
      send_item(CMD_PUSH_FRONT, 32'h3333_3333);
      // Popping the only entry empties the deque and rewinds both ends.
      send_item(CMD_POP_REAR,   32'h0000_0000);
      // Fill from the rear until the deque is full.
      send_item(CMD_PUSH_REAR,  32'h8000_0000);
      send_item(CMD_PUSH_REAR,  32'h7fff_ffff);
      send_item(CMD_PUSH_REAR,  32'h0000_0000);
      send_item(CMD_PUSH_REAR,  32'hffff_ffff);
      send_item(CMD_PUSH_REAR,  32'h5555_5555);
      send_item(CMD_PUSH_REAR,  32'haaaa_aaaa);
      send_item(CMD_PUSH_REAR,  32'h0000_0001);
      send_item(CMD_PUSH_REAR,  32'hffff_fffe);
      // Both pushes are refused as full, then a full traverse.
      send_item(CMD_PUSH_REAR,  32'h4444_4444);
      send_item(CMD_PUSH_FRONT, 32'h4444_4444);
      send_item(CMD_TRAVERSE,   32'h0000_0000);
      // Freeing the front slot makes a push rear find no room at the rear.
      send_item(CMD_POP_FRONT,  32'h0000_0000);
      send_item(CMD_PUSH_REAR,  32'h6666_6666);
      send_item(CMD_PUSH_FRONT, 32'h1234_5678);
      send_item(CMD_MOD_FRONT,  32'hdead_beef);
      send_item(CMD_MOD_REAR,   32'h0bad_f00d);
      // The unknown code must yield nothing.
      send_item(CmdUnused,      32'hffff_ffff);
      wait_until_drained();

      // Random part, sent in bursts of random length with random gaps. Fill
      // and drain phases alternate every 40 commands.
      sent        = 0;
      burst_left  = 0;
      hold_issued = 1'b0;
      pause_done  = 1'b0;
      while (sent < RandomItems) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // No gaps while the result side holds off, so the block backs up.
            if (gap > 0 && !hold_request) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 12);
         end
         if (sent >= 60 && !hold_issued) begin
            hold_request = 1'b1;
            hold_issued  = 1'b1;
         end
         if (sent >= 150 && !pause_done) begin
            wait_until_drained();
            pause_done = 1'b1;
         end
         cmd = pick_command(((sent / 40) % 2) == 0);
         send_item(cmd, pick_word());
         if (cmd != CmdUnused) sent++;
         burst_left--;
      end

      // Let every predicted item arrive, then watch a little longer.
      wait_until_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_items == 0) begin
         $display("array_deque_engine_core verification clean");
      end else begin
         $display("array_deque_engine_core verification failed");
      end
      $finish;
   end

endmodule
